// File: hw/rtl/idct_pkg.sv
package idct_pkg;

	localparam int COEF_WIDTH = 12;
	localparam int ROW_WIDTH  = 20;
	localparam int SAMPLE_WIDTH = 16;
	localparam int ACC_WIDTH  = 40;
	localparam int ROW_SHIFT  = 11;
	localparam int COL_SHIFT  = 15;

	localparam logic signed [13:0] K1 = 14'sd4017;
	localparam logic signed [13:0] K2 = 14'sd3784;
	localparam logic signed [13:0] K3 = 14'sd3406;
	localparam logic signed [13:0] K4 = 14'sd2896;
	localparam logic signed [13:0] K5 = 14'sd2276;
	localparam logic signed [13:0] K6 = 14'sd1567;
	localparam logic signed [13:0] K7 = 14'sd799;
	localparam logic signed [8:0]  RSQ_NUM = 9'sd181;

	typedef logic signed [ACC_WIDTH-1:0] acc_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_ROW,
		ST_COL,
		ST_DRAIN
	} idct_state_t;

	// product by (181/256), truncating toward zero
	function automatic acc_t rsq_mul(input acc_t x);
		logic signed [ACC_WIDTH+8:0] p;
		logic signed [ACC_WIDTH+8:0] b;
		begin
			p = $signed({{9{x[ACC_WIDTH-1]}}, x}) * $signed({{(ACC_WIDTH){1'b0}}, RSQ_NUM});
			b = p[ACC_WIDTH+8] ? (p + 49'sd255) : p;
			rsq_mul = acc_t'(b >>> 8);
		end
	endfunction

endpackage

// File: hw/rtl/idct_line.sv
// One 1-D butterfly over eight values, three stages deep.
module idct_line (
	input  logic                         clk,
	input  logic                         en,
	input  logic                         col,
	input  idct_pkg::acc_t               v [8],
	output idct_pkg::acc_t               o [8]
);
	import idct_pkg::*;

	acc_t s_s1 [8];
	logic col_s1, col_s2, col_s3;
	acc_t t_s2 [8];
	acc_t u5_s3, u6_s3;
	acc_t t0_s3, t1_s3, t2_s3, t3_s3, t4_s3, t7_s3;
	acc_t r [8];

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1[0] <= (v[0] + v[4]) * K4;
			s_s1[1] <= (v[0] - v[4]) * K4;
			s_s1[3] <= v[2] * K2 + v[6] * K6;
			s_s1[2] <= v[2] * K6 - v[6] * K2;
			s_s1[7] <= v[1] * K1 + v[7] * K7;
			s_s1[4] <= v[1] * K7 - v[7] * K1;
			s_s1[6] <= v[5] * K5 + v[3] * K3;
			s_s1[5] <= v[5] * K3 - v[3] * K5;
			col_s1 <= col;
			t_s2[0] <= s_s1[0] + s_s1[3];
			t_s2[1] <= s_s1[1] + s_s1[2];
			t_s2[3] <= s_s1[0] - s_s1[3];
			t_s2[2] <= s_s1[1] - s_s1[2];
			t_s2[4] <= s_s1[4] + s_s1[5];
			t_s2[5] <= s_s1[4] - s_s1[5];
			t_s2[7] <= s_s1[7] + s_s1[6];
			t_s2[6] <= s_s1[7] - s_s1[6];
			col_s2 <= col_s1;
			u6_s3 <= rsq_mul(t_s2[5] + t_s2[6]);
			u5_s3 <= rsq_mul(t_s2[6] - t_s2[5]);
			t0_s3 <= t_s2[0];
			t1_s3 <= t_s2[1];
			t2_s3 <= t_s2[2];
			t3_s3 <= t_s2[3];
			t4_s3 <= t_s2[4];
			t7_s3 <= t_s2[7];
			col_s3 <= col_s2;
		end
	end

	always_comb begin
		r[0] = t0_s3 + t7_s3;
		r[1] = t1_s3 + u6_s3;
		r[2] = t2_s3 + u5_s3;
		r[3] = t3_s3 + t4_s3;
		r[4] = t3_s3 - t4_s3;
		r[5] = t2_s3 - u5_s3;
		r[6] = t1_s3 - u6_s3;
		r[7] = t0_s3 - t7_s3;
		for (int i = 0; i < 8; i++)
			o[i] = col_s3 ? (r[i] >>> COL_SHIFT) : (r[i] >>> ROW_SHIFT);
	end

endmodule

// File: hw/rtl/idct_8x8_fixed_point.sv
// 8x8 inverse DCT. Coefficients enter row-major, one request per clock, into a
// banked coefficient store. After the 64th the block runs eight row lines and
// eight column lines through one three-stage butterfly, one line per cycle.
// Each pass runs eight line reads, the registered store read and three butterfly
// stages. It then emits 64 samples row-major, one per clock while out_stall is
// low, the last one marked. The input is stalled from the 64th coefficient
// until the block's last sample has been taken, so output stalls lengthen the
// block by their length.
module idct_8x8_fixed_point (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [idct_pkg::COEF_WIDTH-1:0] coefficient,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [15:0]                     sample,
	output logic                                   last
);
	import idct_pkg::*;

	idct_state_t state_q, state_d;
	logic [5:0] load_q;
	logic [3:0] line_q;
	logic [5:0] out_q;
	logic [5:0] rd_ptr;
	logic [2:0] rd_line_s1;
	logic signed [COEF_WIDTH-1:0] coef_rd_q [8];
	logic signed [ROW_WIDTH-1:0] row_rd_q [8];
	logic signed [SAMPLE_WIDTH-1:0] out_rd_q [8];
	acc_t v [8];
	acc_t o [8];
	logic issue, wr_row, wr_col;
	logic [2:0] wl;
	logic accept_in, accept_out;

	assign accept_in  = in_valid && !in_stall;
	assign accept_out = out_valid && !out_stall;
	assign issue  = (state_q == ST_ROW || state_q == ST_COL) && line_q < 4'd8;
	assign wl     = 3'(line_q - 4'd4);
	assign wr_row = state_q == ST_ROW && line_q >= 4'd4;
	assign wr_col = state_q == ST_COL && line_q >= 4'd4;
	// read ahead so the registered sample follows out_q
	assign rd_ptr = accept_out ? out_q + 6'd1 : out_q;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			if (state_q == ST_ROW)
				v[i] = acc_t'(coef_rd_q[i]);
			else
				v[i] = acc_t'(row_rd_q[3'(i) + rd_line_s1]);
		end
	end

	idct_line u_line (
		.clk(clk), .en(1'b1), .col(state_q == ST_COL), .v(v), .o(o)
	);

	always_ff @(posedge clk) begin
		rd_line_s1 <= line_q[2:0];
	end

	// Coefficients: bank per column. Row results: row r, column c in bank
	// (r + c) mod 8 at address c, so a row write and a column read touch each
	// bank once. Samples: bank per row.
	for (genvar b = 0; b < 8; b++) begin : g_bank
		logic signed [COEF_WIDTH-1:0] coef_mem [8];
		logic signed [ROW_WIDTH-1:0] row_mem [8];
		logic signed [SAMPLE_WIDTH-1:0] out_mem [8];
		logic [2:0] wc;

		assign wc = 3'(b) - wl;

		always_ff @(posedge clk) begin
			if (accept_in && load_q[2:0] == 3'(b))
				coef_mem[load_q[5:3]] <= coefficient;
			if (wr_row)
				row_mem[wc] <= ROW_WIDTH'(o[wc]);
			if (wr_col)
				out_mem[wl] <= SAMPLE_WIDTH'(o[b]);
			coef_rd_q[b] <= coef_mem[line_q[2:0]];
			row_rd_q[b]  <= row_mem[line_q[2:0]];
			out_rd_q[b]  <= out_mem[rd_ptr[2:0]];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:  if (accept_in && load_q == 6'd63) state_d = ST_ROW;
			ST_ROW:   if (line_q == 4'd11) state_d = ST_COL;
			ST_COL:   if (line_q == 4'd11) state_d = ST_DRAIN;
			ST_DRAIN: if (accept_out && out_q == 6'd63) state_d = ST_LOAD;
			default:  state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			load_q  <= '0;
			line_q  <= '0;
			out_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept_in)
				load_q <= load_q + 6'd1;
			if (state_d != state_q)
				line_q <= '0;
			else if (state_q == ST_ROW || state_q == ST_COL)
				line_q <= line_q + 4'd1;
			if (accept_out)
				out_q <= out_q + 6'd1;
		end
	end

	always_comb begin
		in_stall  = state_q != ST_LOAD;
		out_valid = state_q == ST_DRAIN;
		sample    = out_rd_q[out_q[5:3]];
		last      = out_q == 6'd63;
	end

	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && !in_stall)) else $error("load and drain overlap");
	a_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROW) |-> line_q <= 4'd11) else $error("line count overrun");
	a_drain_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> out_q == 6'd0) else $error("drain not aligned");
	a_issue_used: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> !out_valid) else $error("issue in drain");

endmodule
